// ===== src/sm64_pkg.sv =====
// ----------------------------------------------------------------------------
// sm64_pkg: shared types and constants of the SplitMix64 bounded generator
// Holds the mixer constants, input mode codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sm64_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CNT_W  = $clog2(HALF_W);

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned SHIFT_IN  = 30;
  localparam int unsigned SHIFT_MID = 27;
  localparam int unsigned SHIFT_OUT = 31;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESEED = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_HALF   = 2'd2,
    MODE_RANGE  = 2'd3
  } mode_t;

  // Which 32x32 partial product of the low 64 bits to form
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_WORD = 2'd0,
    OUT_HALF = 2'd1,
    OUT_REM  = 2'd2,
    OUT_ZERO = 2'd3
  } out_sel_t;

  typedef enum logic {
    DIV_SRC_THR  = 1'b0,
    DIV_SRC_DRAW = 1'b1
  } div_src_t;

  typedef struct packed {
    logic     capture;
    logic     reseed;
    logic     advance;
    logic     pass_b;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     xs_en;
    logic     div_load;
    div_src_t div_src;
    logic     div_step;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic bound_le1;
    logic draw_ge;
  } status_t;

endpackage

// ===== src/sm64_if.sv =====
// ----------------------------------------------------------------------------
// sm64 channel interfaces
// Request channel (mode, seed, bound) and response channel (value), each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sm64_req_if;
  logic                             valid;
  logic                             ready;
  logic [sm64_pkg::MODE_W-1:0]      mode;
  logic [sm64_pkg::WORD_W-1:0]      seed;
  logic [sm64_pkg::HALF_W-1:0]      bound;

  modport source (output valid, mode, seed, bound, input ready);
  modport sink   (input valid, mode, seed, bound, output ready);
endinterface

interface sm64_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sm64_pkg::WORD_W-1:0]      value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

// ===== src/splitmix64_bounded_random.sv =====
// ----------------------------------------------------------------------------
// splitmix64_bounded_random: SplitMix64 generator with bounded draws
// Top level joining the sequencer and the datapath to the request and
// response channels.
// ----------------------------------------------------------------------------
// One request transaction is worked on at a time; a new request is taken as
// soon as the previous one has handed its result to the output register, even
// if that result still waits on the response channel. A reseed returns
// nothing. A 64-bit or 32-bit draw runs one state advance, two mix passes on
// the shared 32x32 multiplier (three partial products of the low 64 bits plus
// accumulate), one xor-shift per pass and a load of the output register. A
// range draw with bound 0 or 1 returns zero without touching the state. Any
// other range draw first runs the restoring divider to get the rejection
// threshold 2^32 mod bound, then makes 32-bit draws (more than half are
// accepted) until one is kept, then runs the divider again for the final
// remainder. The divider, at one remainder bit per cycle, dominates. The
// generator state resets to the golden-ratio increment.
// ----------------------------------------------------------------------------
module splitmix64_bounded_random (
  input  logic        clk,
  input  logic        rst,
  sm64_req_if.sink    req,
  sm64_rsp_if.source  rsp
);
  import sm64_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns handshake, output valid and the step order
  sm64_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_mode   (req.mode),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: generator state, mixer, divider and output register
  sm64_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .seed   (req.seed),
    .bound  (req.bound),
    .value  (rsp.value)
  );

endmodule

// ===== src/sm64_datapath.sv =====
// ----------------------------------------------------------------------------
// sm64_datapath: generator state, mixer and remainder unit
// Shared 32x32 multiplier builds each 64-bit product from three partial
// products; a restoring divider yields one remainder bit per cycle.
// ----------------------------------------------------------------------------
module sm64_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sm64_pkg::cmd_t              cmd,
  output sm64_pkg::status_t           status,
  input  logic [sm64_pkg::WORD_W-1:0] seed,
  input  logic [sm64_pkg::HALF_W-1:0] bound,
  output logic [sm64_pkg::WORD_W-1:0] value
);
  import sm64_pkg::*;

  logic [WORD_W-1:0] gen_state;
  logic [WORD_W-1:0] z;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] value_r;
  logic [HALF_W-1:0] bound_r;
  logic [HALF_W-1:0] dvd;
  logic [HALF_W-1:0] rem;

  logic [WORD_W-1:0] mix_const;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] adv_sum;
  logic [HALF_W:0]   trial;
  logic [HALF_W:0]   diff;
  logic              fits;

  assign mix_const = cmd.pass_b ? MIX_MUL_B : MIX_MUL_A;
  assign adv_sum   = gen_state + GOLDEN_INC;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = z[HALF_W-1:0];
        mul_b = mix_const[HALF_W-1:0];
      end
      MUL_LH: begin
        mul_a = z[HALF_W-1:0];
        mul_b = mix_const[WORD_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = z[WORD_W-1:HALF_W];
        mul_b = mix_const[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Restoring step: shift in next dividend bit, subtract when it fits
  assign trial = {rem, dvd[HALF_W-1]};
  assign diff  = trial - {1'b0, bound_r};
  assign fits  = trial >= {1'b0, bound_r};

  assign status.bound_le1 = (bound[HALF_W-1:1] == '0);
  assign status.draw_ge   = (z[WORD_W-1:HALF_W] >= rem);
  assign value            = value_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= GOLDEN_INC;
    end else if (cmd.reseed) begin
      gen_state <= (seed == '0) ? GOLDEN_INC : seed;
    end else if (cmd.advance) begin
      gen_state <= adv_sum;
    end
  end

  always_ff @(posedge clk) begin
    prod <= WORD_W'(mul_a) * WORD_W'(mul_b);

    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= {acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc[HALF_W-1:0]};
      default:  acc <= acc;
    endcase

    if (cmd.advance) begin
      z <= adv_sum ^ (adv_sum >> SHIFT_IN);
    end else if (cmd.xs_en) begin
      z <= cmd.pass_b ? (acc ^ (acc >> SHIFT_OUT)) : (acc ^ (acc >> SHIFT_MID));
    end

    if (cmd.capture) begin
      bound_r <= bound;
    end

    if (cmd.div_load) begin
      dvd <= (cmd.div_src == DIV_SRC_THR) ? (HALF_W'(0) - bound) : z[WORD_W-1:HALF_W];
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[HALF_W-2:0], 1'b0};
      rem <= fits ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
    end

    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_WORD: value_r <= z;
        OUT_HALF: value_r <= {{HALF_W{1'b0}}, z[WORD_W-1:HALF_W]};
        OUT_REM:  value_r <= {{HALF_W{1'b0}}, rem};
        default:  value_r <= '0;
      endcase
    end
  end

endmodule

// ===== src/sm64_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm64_ctrl: sequencer of the SplitMix64 bounded generator
// Steps the datapath through advance, two multiply passes, rejection check
// and remainder steps; owns the handshake and output valid flag.
// ----------------------------------------------------------------------------
module sm64_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sm64_pkg::MODE_W-1:0] in_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  sm64_pkg::status_t           status,
  output sm64_pkg::cmd_t              cmd
);
  import sm64_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ADV  = 10'b00_0000_0010,
    S_MUL0 = 10'b00_0000_0100,
    S_MUL1 = 10'b00_0000_1000,
    S_MUL2 = 10'b00_0001_0000,
    S_MUL3 = 10'b00_0010_0000,
    S_SHF  = 10'b00_0100_0000,
    S_CHK  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t            state, state_next;
  logic [MODE_W-1:0] mode_r, mode_r_next;
  logic              pass_b, pass_b_next;
  logic              zero_r, zero_r_next;
  logic              final_div, final_div_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              out_valid_r, out_valid_next;

  assign out_valid = out_valid_r;

  always_comb begin
    state_next     = state;
    mode_r_next    = mode_r;
    pass_b_next    = pass_b;
    zero_r_next    = zero_r;
    final_div_next = final_div;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.pass_b     = pass_b;
    cmd.mul_sel    = MUL_LL;
    cmd.acc_op     = ACC_HOLD;
    cmd.div_src    = DIV_SRC_THR;
    cmd.out_sel    = OUT_ZERO;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          mode_r_next = in_mode;
          zero_r_next = 1'b0;
          case (in_mode)
            MODE_RESEED: cmd.reseed = 1'b1;
            MODE_WORD,
            MODE_HALF:   state_next = S_ADV;
            default: begin
              if (status.bound_le1) begin
                zero_r_next = 1'b1;
                state_next  = S_OUT;
              end else begin
                cmd.div_load   = 1'b1;
                cmd.div_src    = DIV_SRC_THR;
                cnt_next       = '0;
                final_div_next = 1'b0;
                state_next     = S_DIV;
              end
            end
          endcase
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        pass_b_next = 1'b0;
        state_next  = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_sel = MUL_LL;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_sel = MUL_LH;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sel = MUL_HL;
        cmd.acc_op  = ACC_ADD;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_SHF;
      end
      S_SHF: begin
        cmd.xs_en = 1'b1;
        if (!pass_b) begin
          pass_b_next = 1'b1;
          state_next  = S_MUL0;
        end else if (mode_r == MODE_RANGE) begin
          state_next = S_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_CHK: begin
        if (status.draw_ge) begin
          cmd.div_load   = 1'b1;
          cmd.div_src    = DIV_SRC_DRAW;
          cnt_next       = '0;
          final_div_next = 1'b1;
          state_next     = S_DIV;
        end else begin
          state_next = S_ADV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (&cnt) begin
          state_next = final_div ? S_OUT : S_ADV;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          if (zero_r) begin
            cmd.out_sel = OUT_ZERO;
          end else begin
            case (mode_r)
              MODE_WORD: cmd.out_sel = OUT_WORD;
              MODE_HALF: cmd.out_sel = OUT_HALF;
              default:   cmd.out_sel = OUT_REM;
            endcase
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
      pass_b      <= 1'b0;
      zero_r      <= 1'b0;
      final_div   <= 1'b0;
      cnt         <= '0;
      mode_r      <= MODE_RESEED;
    end else begin
      state       <= state_next;
      out_valid_r <= out_valid_next;
      pass_b      <= pass_b_next;
      zero_r      <= zero_r_next;
      final_div   <= final_div_next;
      cnt         <= cnt_next;
      mode_r      <= mode_r_next;
    end
  end

endmodule
